@@ src/lmc_pkg.sv @@
// Shared types, constants and helpers of the light mode controller.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package lmc_pkg;

    localparam int TICK_W = 16;
    localparam int MODE_W = 3;
    localparam int POS_W  = 5;
    localparam int IDX_W  = 3;

    // Pattern length and reset values of the timing registers
    localparam logic [POS_W-1:0]  SOS_LEN          = 5'd18;
    localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;
    localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] CYCLE_RESET      = 16'd2000;
    localparam logic [TICK_W-1:0] FLASH_HALF_RESET = 16'd500;
    localparam logic [TICK_W-1:0] DOT_RESET        = 16'd200;
    localparam logic [TICK_W-1:0] DASH_RESET       = 16'd600;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 3'd0;
    localparam logic [IDX_W-1:0] REG_CYCLE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_FLASH_HALF = 3'd2;
    localparam logic [IDX_W-1:0] REG_DOT        = 3'd3;
    localparam logic [IDX_W-1:0] REG_DASH       = 3'd4;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RED_GREEN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WHITE_A   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WHITE_B   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMBO     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALL_WHITE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FLASH     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SOS       = 3'd7;

    typedef struct packed {
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] cycle_ticks;
        logic [TICK_W-1:0] flash_half_ticks;
        logic [TICK_W-1:0] dot_ticks;
        logic [TICK_W-1:0] dash_ticks;
    } lmc_cfg_t;

    typedef struct packed {
        logic red;
        logic green;
        logic white_a;
        logic white_b;
    } lmc_lamps_t;

    // Count up by one, stick at the top
    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        sat_inc = (v == TICK_MAX) ? v : v + 1'b1;
    endfunction

    // Even pattern entries 6..11 (second letter) are dashes
    function automatic logic sos_is_dash(input logic [POS_W-1:0] p);
        logic [POS_W-2:0] elem;
        elem = p[POS_W-1:1];
        sos_is_dash = !p[0] && (elem inside {4'd3, 4'd4, 4'd5});
    endfunction

endpackage

@@ src/lmc_mode_ctrl.sv @@
// Button press, hold and mode cycling logic of the light mode controller.
// Depends on lmc_pkg.
`timescale 1ns / 1ps

module lmc_mode_ctrl
    import lmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              button_level,
    input  lmc_cfg_t          cfg,
    output logic [MODE_W-1:0] mode_next
);

    logic              button_prev_reg, button_prev_next;
    logic [TICK_W-1:0] press_count_reg, press_count_next;
    logic              hold_flag_reg, hold_flag_next;
    logic [TICK_W-1:0] cycle_count_reg, cycle_count_next;
    logic [MODE_W-1:0] current_mode_reg;
    logic [MODE_W-1:0] saved_mode_reg, saved_mode_next;

    logic pressed;
    logic fall;
    logic rise;

    assign pressed = !button_level;
    assign fall    = pressed && button_prev_reg;
    assign rise    = button_level && !button_prev_reg;

    // Work out the new counters and mode for one tick
    always_comb
    begin
        press_count_next = fall ? '0 : press_count_reg;
        hold_flag_next   = fall ? 1'b0 : hold_flag_reg;
        cycle_count_next = cycle_count_reg;
        mode_next        = current_mode_reg;
        saved_mode_next  = saved_mode_reg;

        // enter hold once the press lasts long enough
        if (pressed && !hold_flag_next && press_count_next >= cfg.long_press_ticks)
        begin
            hold_flag_next   = 1'b1;
            cycle_count_next = '0;
            if (mode_next == MODE_OFF)
            begin
                mode_next = MODE_RED_GREEN;
            end
        end

        // advance the mode while held, skipping off
        if (pressed && hold_flag_next && cycle_count_next >= cfg.cycle_ticks)
        begin
            mode_next = mode_next + 1'b1;
            if (mode_next == MODE_OFF)
            begin
                mode_next = MODE_RED_GREEN;
            end
            cycle_count_next = '0;
        end

        // short press toggles between off and the last active mode
        if (rise && !hold_flag_next)
        begin
            if (mode_next != MODE_OFF)
            begin
                saved_mode_next = mode_next;
                mode_next       = MODE_OFF;
            end
            else
            begin
                mode_next = saved_mode_reg;
            end
        end

        // count elapsed ticks of the press or of the hold
        if (pressed)
        begin
            if (hold_flag_next)
            begin
                cycle_count_next = sat_inc(cycle_count_next);
            end
            else
            begin
                press_count_next = sat_inc(press_count_next);
            end
        end

        button_prev_next = button_level;
    end

    // Commit the state when a beat is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_prev_reg  <= 1'b1;
            press_count_reg  <= '0;
            hold_flag_reg    <= 1'b0;
            cycle_count_reg  <= '0;
            current_mode_reg <= MODE_COMBO;
            saved_mode_reg   <= MODE_COMBO;
        end
        else if (enable)
        begin
            button_prev_reg  <= button_prev_next;
            press_count_reg  <= press_count_next;
            hold_flag_reg    <= hold_flag_next;
            cycle_count_reg  <= cycle_count_next;
            current_mode_reg <= mode_next;
            saved_mode_reg   <= saved_mode_next;
        end
    end

endmodule

@@ src/lmc_lamp_drive.sv @@
// Flash and SOS timers and the lamp decode of the light mode controller.
// Depends on lmc_pkg.
`timescale 1ns / 1ps

module lmc_lamp_drive
    import lmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic [MODE_W-1:0] mode,
    input  lmc_cfg_t          cfg,
    output lmc_lamps_t        lamps
);

    logic [TICK_W-1:0] flash_count_reg, flash_count_next;
    logic              flash_level_reg, flash_level_next;
    logic [TICK_W-1:0] sos_count_reg, sos_count_next;
    logic [POS_W-1:0]  sos_position_reg, sos_position_next;
    logic [TICK_W-1:0] entry_ticks;
    logic              sos_lit;

    // Free-running flash timer
    always_comb
    begin
        flash_count_next = sat_inc(flash_count_reg);
        flash_level_next = flash_level_reg;
        if (flash_count_next >= cfg.flash_half_ticks)
        begin
            flash_count_next = '0;
            flash_level_next = !flash_level_reg;
        end
    end

    // SOS timer, runs only in SOS mode
    always_comb
    begin
        sos_position_next = (sos_position_reg >= SOS_LEN) ? '0 : sos_position_reg;
        sos_count_next    = sos_count_reg;
        entry_ticks       = sos_is_dash(sos_position_next) ? cfg.dash_ticks : cfg.dot_ticks;
        if (mode == MODE_SOS)
        begin
            sos_count_next = sat_inc(sos_count_reg);
            if (sos_count_next >= entry_ticks)
            begin
                sos_count_next    = '0;
                sos_position_next = sos_position_next + 1'b1;
                if (sos_position_next >= SOS_LEN)
                begin
                    sos_position_next = '0;
                end
            end
        end
        sos_lit = !sos_position_next[0];
    end

    // Decode the lamp sections from the mode
    always_comb
    begin
        lamps = '0;
        case (mode)
            MODE_RED_GREEN:
            begin
                lamps.red   = 1'b1;
                lamps.green = 1'b1;
            end
            MODE_WHITE_A:   lamps.white_a = 1'b1;
            MODE_WHITE_B:   lamps.white_b = 1'b1;
            MODE_COMBO:
            begin
                lamps.red     = 1'b1;
                lamps.green   = 1'b1;
                lamps.white_b = 1'b1;
            end
            MODE_ALL_WHITE:
            begin
                lamps.white_a = 1'b1;
                lamps.white_b = 1'b1;
            end
            MODE_FLASH:
            begin
                lamps.white_a = flash_level_next;
                lamps.white_b = flash_level_next;
            end
            MODE_SOS:
            begin
                lamps.white_a = sos_lit;
                lamps.white_b = sos_lit;
            end
            default:        lamps = '0;
        endcase
    end

    // Commit the timers when a beat is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_count_reg  <= '0;
            flash_level_reg  <= 1'b0;
            sos_count_reg    <= '0;
            sos_position_reg <= '0;
        end
        else if (enable)
        begin
            flash_count_reg  <= flash_count_next;
            flash_level_reg  <= flash_level_next;
            sos_count_reg    <= sos_count_next;
            sos_position_reg <= sos_position_next;
        end
    end

endmodule

@@ src/light_mode_controller_core.sv @@
// Light mode controller: one button tick in, one lamp drive word out.
// Top level; depends on lmc_pkg, lmc_mode_ctrl and lmc_lamp_drive.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one beat per millisecond tick: tdata[0] is the sampled
//   button level, low while pressed. m_axis returns one beat per input beat:
//   the four lamp section drives and the current mode.
//   The cfg channel writes the five timing registers (long press, cycle,
//   flash half period, dot, dash) by index; cfg_ready is always high and
//   writes to indexes above four are dropped. Write only while idle.
// Timing
//   A beat accepted on s_axis is held in the input register, processed into
//   the result register and presented on m_axis from then on.
//   One beat per cycle is sustained; the input register and the result
//   register form a two-entry pipe, so s_axis keeps accepting while a result
//   waits as long as the result register drains in the same cycle.
// Reset
//   rst_n clears both pipe stages, returns the timers to zero, selects the
//   combo mode and loads the default timing registers.
// Stall
//   With m_axis_tready low, the result holds and the input register fills;
//   s_axis_tready then drops until the result is taken.
module light_mode_controller_core
    import lmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [0] button_level, [7:1] zero
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] lamp_red, [1] lamp_green, [2] lamp_white_a, [3] lamp_white_b,
    // [6:4] mode, [7] zero
    output logic [7:0]        m_axis_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic              in_button_reg;
    logic              out_valid_reg;
    lmc_lamps_t        out_lamps_reg;
    logic [MODE_W-1:0] out_mode_reg;
    lmc_cfg_t          cfg_reg;

    logic              advance;
    logic              in_take;
    logic [MODE_W-1:0] mode_next;
    lmc_lamps_t        lamps_next;

    // Pipe control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.cycle_ticks      <= CYCLE_RESET;
            cfg_reg.flash_half_ticks <= FLASH_HALF_RESET;
            cfg_reg.dot_ticks        <= DOT_RESET;
            cfg_reg.dash_ticks       <= DASH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                REG_CYCLE:      cfg_reg.cycle_ticks      <= cfg_data;
                REG_FLASH_HALF: cfg_reg.flash_half_ticks <= cfg_data;
                REG_DOT:        cfg_reg.dot_ticks        <= cfg_data;
                REG_DASH:       cfg_reg.dash_ticks       <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_button_reg <= s_axis_tdata[0];
        end
    end

    lmc_mode_ctrl u_mode_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (advance),
        .button_level (in_button_reg),
        .cfg          (cfg_reg),
        .mode_next    (mode_next)
    );

    lmc_lamp_drive u_lamp_drive (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (advance),
        .mode   (mode_next),
        .cfg    (cfg_reg),
        .lamps  (lamps_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_lamps_reg <= lamps_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_mode_reg, out_lamps_reg.white_b,
                            out_lamps_reg.white_a, out_lamps_reg.green, out_lamps_reg.red};

`ifndef NO_ASSERTIONS
    // A processed beat always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    // A waiting input beat is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled input beat was lost");

    // Off mode keeps every lamp dark
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_mode_reg == MODE_OFF) |-> (out_lamps_reg == '0))
        else $error("lamp lit in off mode");

    // Combo mode drives red, green and the second white
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_mode_reg == MODE_COMBO)
            |-> (out_lamps_reg.red && out_lamps_reg.green
                 && !out_lamps_reg.white_a && out_lamps_reg.white_b))
        else $error("combo mode lamp pattern wrong");
`endif

endmodule
